// ===== design/ed3s_pkg.sv =====
// Shared constants for the 3D distance core: default widths, output range and
// the early saturation limit. No dependencies.
`default_nettype none

package ed3s_pkg;

   localparam int COORD_WIDTH_DEFAULT   = 24;
   localparam int FRACTION_BITS_DEFAULT = 5;

   localparam int DIST_WIDTH = 16;
   localparam logic [DIST_WIDTH-1:0] DIST_MAX = 16'hFFFF;

   // a component difference at or above 2^BIG_BITS always saturates
   localparam int BIG_BITS = 28;

endpackage

`default_nettype wire

// ===== design/euclidean_distance_3d_saturating_core.sv =====
// Rounded, saturating distance between two 3D fixed-point points, fully pipelined.
// Depends on ed3s_pkg for default widths and the output range.
`default_nettype none

// One request goes in per clock while req_stall is low, and one response comes
// out for each request. Between them lie a difference stage, a squaring stage,
// a sum stage, a range compare, one square-root stage for each of the
// FRACTION_BITS + 17 root bits, and the output register. Each stage holds its
// request while later stages are stalled and takes the next one as soon as it
// is free, so empty slots close up under any pattern of req_valid and
// rsp_stall. The distance is
// floor(sqrt(dx^2+dy^2+dz^2) / 2^FRACTION_BITS + 1/2) light years, halves
// rounding up; above 65535 it reads 65535 with rsp_clipped set.
module euclidean_distance_3d_saturating_core #(
   parameter int COORD_WIDTH   = ed3s_pkg::COORD_WIDTH_DEFAULT,
   parameter int FRACTION_BITS = ed3s_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic signed [COORD_WIDTH-1:0]   req_first_x,
   input  wire logic signed [COORD_WIDTH-1:0]   req_first_y,
   input  wire logic signed [COORD_WIDTH-1:0]   req_first_z,
   input  wire logic signed [COORD_WIDTH-1:0]   req_second_x,
   input  wire logic signed [COORD_WIDTH-1:0]   req_second_y,
   input  wire logic signed [COORD_WIDTH-1:0]   req_second_z,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [ed3s_pkg::DIST_WIDTH-1:0]      rsp_distance_ly,
   output logic                                 rsp_clipped
);
   import ed3s_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int FB  = FRACTION_BITS;
   // difference magnitude, wide enough to test against 2^BIG_BITS
   localparam int EW  = (CW + 1 > BIG_BITS + 1) ? CW + 1 : BIG_BITS + 1;
   // magnitude carried on once the huge case is split off
   localparam int MW  = (CW + 1 < BIG_BITS) ? CW + 1 : BIG_BITS;
   localparam int SW  = 2 * MW + 2;       // sum of three squares
   localparam int TW  = SW + 2;           // four times the sum
   localparam int RW  = FB + DIST_WIDTH + 1; // root bits below the limit
   localparam int XW  = (TW > 2 * RW) ? TW : 2 * RW;
   localparam int RMW = RW + 2;           // square-root remainder

   // root limit: floor(2*sqrt(S)) >= K exactly when the rounded distance is too big
   localparam longint unsigned K_VAL   = 64'd131071 << FB;
   localparam longint unsigned KSQ_VAL = K_VAL * K_VAL;
   localparam logic [RW:0]     HALF    = (RW + 1)'(64'd1 << FB);

   // ---------------- difference stage ----------------
   logic [2:0][CW-1:0]  pa, pb;
   logic [2:0][EW-1:0]  mag_ext;
   logic [2:0][MW-1:0]  d_mag_in;
   logic                d_big_in;
   logic                d_v_ff, d_big_ff, d_ld;
   logic [2:0][MW-1:0]  d_mag_ff;

   assign pa = {req_first_z, req_first_y, req_first_x};
   assign pb = {req_second_z, req_second_y, req_second_x};

   always_comb begin
      logic signed [CW:0] diff;
      d_big_in = 1'b0;
      for (int l = 0; l < 3; l++) begin
         diff       = $signed({pa[l][CW-1], pa[l]}) - $signed({pb[l][CW-1], pb[l]});
         mag_ext[l] = EW'(diff[CW] ? $unsigned(-diff) : $unsigned(diff));
         d_big_in   = d_big_in | (|mag_ext[l][EW-1:BIG_BITS]);
         d_mag_in[l] = mag_ext[l][MW-1:0];
      end
   end

   // ---------------- squaring stage ----------------
   logic                   m_v_ff, m_big_ff, m_ld;
   logic [2:0][2*MW-1:0]   m_sq_ff;

   // ---------------- sum stage ----------------
   logic                   s_v_ff, s_big_ff, s_ld;
   logic [TW-1:0]          s_t_ff, s_t_in;

   assign s_t_in = {SW'(m_sq_ff[0]) + SW'(m_sq_ff[1]) + SW'(m_sq_ff[2]), 2'b00};

   // ---------------- square root, one bit per stage ----------------
   // index 0 is the range-compare stage, index RW holds the finished root
   logic [RW:0]               q_v_ff, q_clip_ff, q_ld;
   logic [RW:0][2*RW-1:0]     q_rad_ff;
   logic [RW:0][RMW-1:0]      q_rem_ff;
   logic [RW:0][RW-1:0]       q_root_ff;
   logic                      c_clip_in;

   assign c_clip_in = s_big_ff | (XW'(s_t_ff) >= XW'(KSQ_VAL));

   // ---------------- output stage ----------------
   logic                   rsp_valid_ff, o_ld;
   logic [DIST_WIDTH-1:0]  dist_ff, dist_in;
   logic                   clip_ff;
   logic [RW:0]            rnd;

   assign rnd     = {1'b0, q_root_ff[RW]} + HALF;
   assign dist_in = q_clip_ff[RW] ? DIST_MAX : rnd[FB+DIST_WIDTH:FB+1];

   // a stage loads when it is empty or the stage after it loads
   assign o_ld      = ~rsp_valid_ff | ~rsp_stall;
   assign q_ld[RW]  = ~q_v_ff[RW] | o_ld;
   assign s_ld      = ~s_v_ff | q_ld[0];
   assign m_ld      = ~m_v_ff | s_ld;
   assign d_ld      = ~d_v_ff | m_ld;
   assign req_stall = ~d_ld;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff       <= 1'b0;
         m_v_ff       <= 1'b0;
         s_v_ff       <= 1'b0;
         q_v_ff[0]    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (d_ld)    d_v_ff       <= req_valid;
         if (m_ld)    m_v_ff       <= d_v_ff;
         if (s_ld)    s_v_ff       <= m_v_ff;
         if (q_ld[0]) q_v_ff[0]    <= s_v_ff;
         if (o_ld)    rsp_valid_ff <= q_v_ff[RW];
      end
   end

   always_ff @(posedge clock) begin
      if (d_ld) begin
         d_big_ff <= d_big_in;
         d_mag_ff <= d_mag_in;
      end
      if (m_ld) begin
         m_big_ff <= d_big_ff;
         for (int l = 0; l < 3; l++) begin
            m_sq_ff[l] <= d_mag_ff[l] * d_mag_ff[l];
         end
      end
      if (s_ld) begin
         s_big_ff <= m_big_ff;
         s_t_ff   <= s_t_in;
      end
      if (q_ld[0]) begin
         q_clip_ff[0] <= c_clip_in;
         q_rad_ff[0]  <= (2 * RW)'(s_t_ff);
         q_rem_ff[0]  <= '0;
         q_root_ff[0] <= '0;
      end
      if (o_ld) begin
         dist_ff <= dist_in;
         clip_ff <= q_clip_ff[RW];
      end
   end

   for (genvar i = 0; i < RW; i++) begin : g_root
      logic [RMW+1:0] cur, trial;
      logic           ge;

      assign q_ld[i] = ~q_v_ff[i] | q_ld[i+1];
      assign cur     = {q_rem_ff[i], q_rad_ff[i][2*RW-1:2*RW-2]};
      assign trial   = (RMW + 2)'({q_root_ff[i], 2'b01});
      assign ge      = cur >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            q_v_ff[i+1] <= 1'b0;
         end else if (q_ld[i+1]) begin
            q_v_ff[i+1] <= q_v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (q_ld[i+1]) begin
            q_clip_ff[i+1] <= q_clip_ff[i];
            q_rad_ff[i+1]  <= {q_rad_ff[i][2*RW-3:0], 2'b00};
            q_rem_ff[i+1]  <= RMW'(ge ? cur - trial : cur);
            q_root_ff[i+1] <= {q_root_ff[i][RW-2:0], ge};
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance_ly = dist_ff;
   assign rsp_clipped     = clip_ff;

`ifndef SYNTHESIS
   // a clipped response always reads full scale
   a_clip_full : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> rsp_distance_ly == DIST_MAX)
      else $error("clipped response not at full scale");

   // an unclipped root stays below the saturation limit
   a_root_bound : assert property (@(posedge clock) disable iff (reset)
      q_v_ff[RW] && !q_clip_ff[RW] |-> 64'(q_root_ff[RW]) < K_VAL)
      else $error("root beyond limit on unclipped request");

   // square-root invariant: remainder never exceeds twice the root
   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      q_v_ff[RW] && !q_clip_ff[RW] |->
         (RMW + 1)'(q_rem_ff[RW]) <= (RMW + 1)'({q_root_ff[RW], 1'b0}))
      else $error("square-root remainder out of range");
`endif

endmodule

`default_nettype wire

// ===== test/euclidean_distance_3d_saturating_core_tb.sv =====
// Self-checking testbench for euclidean_distance_3d_saturating_core: clocked driver and
// monitor, expected distances from an integer square root. Depends on ed3s_pkg and the RTL.
`timescale 1ns / 100ps

module euclidean_distance_3d_saturating_core_tb;

   localparam int CW = ed3s_pkg::COORD_WIDTH_DEFAULT;
   localparam int FB = ed3s_pkg::FRACTION_BITS_DEFAULT;
   localparam int LATENCY = FB + 22;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int C_MAX = (1 << (CW - 1)) - 1;
   localparam int C_MIN = -(1 << (CW - 1));

   typedef logic signed [CW-1:0] coord_type;

   typedef struct {
      coord_type fx, fy, fz, sx, sy, sz;
   } point_pair_type;

   typedef struct {
      logic [ed3s_pkg::DIST_WIDTH-1:0] distance_ly;
      logic                            clipped;
   } distance_type;

   logic   clock = 1'b0;
   logic   reset = 1'b1;
   logic   req_valid = 1'b0;
   logic   req_stall;
   coord_type req_first_x = '0, req_first_y = '0, req_first_z = '0;
   coord_type req_second_x = '0, req_second_y = '0, req_second_z = '0;
   logic   rsp_valid;
   logic   rsp_stall = 1'b0;
   logic [ed3s_pkg::DIST_WIDTH-1:0] rsp_distance_ly;
   logic   rsp_clipped;

   point_pair_type pending_pairs[$];
   distance_type   expected_distances[$];
   point_pair_type offered_pair;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_offs_wanted = 0;
   int hold_offs_done = 0;
   int hold_left = 0;
   int error_count = 0;
   int cycle_count = 0;

   euclidean_distance_3d_saturating_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_first_x     (req_first_x),
      .req_first_y     (req_first_y),
      .req_first_z     (req_first_z),
      .req_second_x    (req_second_x),
      .req_second_y    (req_second_y),
      .req_second_z    (req_second_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_distance_ly (rsp_distance_ly),
      .rsp_clipped     (rsp_clipped)
   );

   always #2 clock = ~clock;

   // floor(sqrt(v)), digit by digit
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > v)
         probe = probe >> 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v = v - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic distance_type predict_distance(point_pair_type p);
      longint          diff[3];
      longint unsigned mag[3];
      longint unsigned sq_sum;
      longint unsigned rounded;
      distance_type    r;
      diff[0] = longint'(p.fx) - longint'(p.sx);
      diff[1] = longint'(p.fy) - longint'(p.sy);
      diff[2] = longint'(p.fz) - longint'(p.sz);
      for (int i = 0; i < 3; i++)
         mag[i] = (diff[i] < 0) ? longint'(-diff[i]) : longint'(diff[i]);
      r.clipped = 1'b0;
      r.distance_ly = ed3s_pkg::DIST_MAX;
      if (mag[0] >= (64'd1 << ed3s_pkg::BIG_BITS) || mag[1] >= (64'd1 << ed3s_pkg::BIG_BITS)
          || mag[2] >= (64'd1 << ed3s_pkg::BIG_BITS)) begin
         r.clipped = 1'b1;
      end else begin
         sq_sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
         // root of 4S gives one extra bit, so halves round up exactly
         rounded = (int_sqrt(sq_sum << 2) + (64'd1 << FB)) >> (FB + 1);
         if (rounded > 64'(ed3s_pkg::DIST_MAX))
            r.clipped = 1'b1;
         else
            r.distance_ly = rounded[ed3s_pkg::DIST_WIDTH-1:0];
      end
      return r;
   endfunction

   task automatic add_pair(input int fx, fy, fz, sx, sy, sz);
      point_pair_type p;
      p.fx = coord_type'(fx);
      p.fy = coord_type'(fy);
      p.fz = coord_type'(fz);
      p.sx = coord_type'(sx);
      p.sy = coord_type'(sy);
      p.sz = coord_type'(sz);
      pending_pairs.push_back(p);
   endtask

   task automatic add_random_pairs(input int count);
      int fx, fy, fz, dx, dy, dz;
      for (int n = 0; n < count; n++) begin
         fx = int'($urandom_range(4000000)) - 2000000;
         fy = int'($urandom_range(4000000)) - 2000000;
         fz = int'($urandom_range(4000000)) - 2000000;
         dx = 0;
         dy = 0;
         dz = 0;
         case ($urandom_range(99)) inside
            [0:39]: begin
               dx = int'($urandom_range(8191)) - 4096;
               dy = int'($urandom_range(8191)) - 4096;
               dz = int'($urandom_range(8191)) - 4096;
            end
            [40:59]: begin
               fx = int'(coord_type'($urandom));
               fy = int'(coord_type'($urandom));
               fz = int'(coord_type'($urandom));
               dx = int'(coord_type'($urandom)) - fx;
               dy = int'(coord_type'($urandom)) - fy;
               dz = int'(coord_type'($urandom)) - fz;
            end
            [60:74]: begin
               // around the saturation edge at 65535.5 ly
               dx = 2097136 + int'($urandom_range(64)) - 32;
               dy = int'($urandom_range(255));
            end
            [75:89]: begin
               // root near a half light year
               dx = 32 * int'($urandom_range(70000)) + 15 + int'($urandom_range(2));
               dz = int'($urandom_range(3));
            end
            default: ;
         endcase
         if ($urandom_range(1)) begin
            dx = -dx;
            dy = -dy;
         end
         add_pair(fx, fy, fz, fx + dx, fy + dy, fz + dz);
      end
   endtask

   task automatic wait_for_drain();
      while (pending_pairs.size() != 0 || req_valid || expected_distances.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      bit offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_distances.push_back(predict_distance(offered_pair));
         if (!req_valid || !req_stall) begin
            offer = pending_pairs.size() != 0 && $urandom_range(99) >= sender_idle_pct;
            if (offer) begin
               offered_pair = pending_pairs.pop_front();
               req_first_x  <= offered_pair.fx;
               req_first_y  <= offered_pair.fy;
               req_first_z  <= offered_pair.fz;
               req_second_x <= offered_pair.sx;
               req_second_y <= offered_pair.sy;
               req_second_z <= offered_pair.sz;
            end
            req_valid <= offer;
         end
      end
   end

   // response stall, with long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_offs_done < hold_offs_wanted) begin
         hold_left = HOLD_OFF_CYCLES - 1;
         hold_offs_done++;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(99) < receiver_stall_pct;
      end
   end

   // response monitor
   always @(posedge clock) begin
      distance_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_distances.size() == 0) begin
            $display("%0t: unexpected response distance_ly=%0d clipped=%0b",
                     $time, rsp_distance_ly, rsp_clipped);
            error_count++;
         end else begin
            want = expected_distances.pop_front();
            if (rsp_distance_ly !== want.distance_ly) begin
               $display("%0t: distance_ly expected %0d actual %0d",
                        $time, want.distance_ly, rsp_distance_ly);
               error_count++;
            end
            if (rsp_clipped !== want.clipped) begin
               $display("%0t: clipped expected %0b actual %0b",
                        $time, want.clipped, rsp_clipped);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // equal points, corners and full span
      add_pair(0, 0, 0, 0, 0, 0);
      add_pair(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
      add_pair(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
      add_pair(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
      add_pair(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
      add_pair(C_MAX, 0, 0, C_MIN, 0, 0);
      add_pair(C_MIN, 0, 0, 0, 0, 0);
      add_pair(0, C_MIN, 0, 0, C_MAX, 0);
      // half light year rounding
      add_pair(15, 0, 0, 0, 0, 0);
      add_pair(16, 0, 0, 0, 0, 0);
      add_pair(0, 47, 0, 0, 0, 0);
      add_pair(0, 48, 0, 0, 0, 0);
      add_pair(0, 0, 0, 0, 0, -16);
      add_pair(11, 11, 0, 0, 0, 0);
      add_pair(12, 12, 0, 0, 0, 0);
      add_pair(1, 1, 1, 0, 0, 0);
      add_pair(96, 128, 0, 0, 0, 0);
      // either side of saturation
      add_pair(2097135, 0, 0, 0, 0, 0);
      add_pair(2097136, 0, 0, 0, 0, 0);
      add_pair(0, 0, -2097136, 0, 0, 0);
      add_pair(2097136, 2097136, 2097136, 0, 0, 0);
      add_pair(int'(coord_type'(24'hAAAAAA)), int'(coord_type'(24'h555555)),
               int'(coord_type'(24'hAAAAAA)), int'(coord_type'(24'h555555)),
               int'(coord_type'(24'hAAAAAA)), int'(coord_type'(24'h555555)));

      add_random_pairs(230);
      wait_for_drain();

      sender_idle_pct = 54;
      add_random_pairs(250);
      wait_for_drain();

      sender_idle_pct = 0;
      receiver_stall_pct = 54;
      add_random_pairs(250);
      wait_for_drain();

      sender_idle_pct = 24;
      receiver_stall_pct = 24;
      add_random_pairs(250);
      wait_for_drain();

      // back-pressure: long response hold-offs fill the pipeline so req_stall rises
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      add_random_pairs(300);
      hold_offs_wanted = 1;
      while (pending_pairs.size() > 150)
         @(posedge clock);
      hold_offs_wanted = 2;
      wait_for_drain();

      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
